// ----- design/rmic_pkg.sv -----
package rmic_pkg;

  localparam int NUM_DIMS = 4;
  localparam int SIZE_W   = 9;
  localparam int COORD_W  = 8;
  localparam int FLAT_W   = 32;
  localparam int RANK_W   = 3;
  localparam int INDEX_W  = 3;

  // dimension sizes cap at 2^DIM_BITS; tied to COORD_W and SIZE_W
  localparam int DIM_BITS = 8;

  // register indexes on the config port
  localparam logic [INDEX_W-1:0] REG_RANK  = 3'd0;
  localparam logic [INDEX_W-1:0] REG_SIZE0 = 3'd1;
  localparam logic [INDEX_W-1:0] REG_SIZE1 = 3'd2;
  localparam logic [INDEX_W-1:0] REG_SIZE2 = 3'd3;
  localparam logic [INDEX_W-1:0] REG_SIZE3 = 3'd4;

  // function codes
  localparam logic FUNC_TO_FLAT  = 1'b0;
  localparam logic FUNC_TO_COORD = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FLAT_W-1:0]  flat_in;
    logic [COORD_W-1:0] coord_in0;
    logic [COORD_W-1:0] coord_in1;
    logic [COORD_W-1:0] coord_in2;
    logic [COORD_W-1:0] coord_in3;
  } item_t;

  typedef struct packed {
    logic [FLAT_W-1:0]  flat_out;
    logic [COORD_W-1:0] coord_out0;
    logic [COORD_W-1:0] coord_out1;
    logic [COORD_W-1:0] coord_out2;
    logic [COORD_W-1:0] coord_out3;
    logic               range_error;
  } result_t;

endpackage

// ----- design/row_major_index_converter.sv -----
// Channel   Valid          Stall          Word
// item      item_valid     item_stall     item   (rmic_pkg::item_t)
// result    result_valid   result_stall   result (rmic_pkg::result_t)
// config    cfg_we         -              cfg_index / cfg_data
//
// 17-stage pipeline: one word per cycle while result_stall does not hold it back.
// Most stages hold the three 32-step restoring dividers, 8 steps per stage.
// Sizes and rank are sampled into the word at entry.
// rst is synchronous; it clears valid bits and sets rank and all sizes to one.
// Each stage holds while its successor is full and stalled; empty stages fill.
module row_major_index_converter #(
  parameter int MAX_RANK = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  rmic_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output rmic_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [rmic_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [rmic_pkg::SIZE_W-1:0]    cfg_data
);
  import rmic_pkg::*;

  localparam int NS = 17;
  localparam logic [RANK_W-1:0] RLIM =
    RANK_W'((MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS);
  localparam logic [16:0] CAP = 17'(1) << DIM_BITS;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_CMP = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;

  typedef struct packed {
    logic                             func;
    logic [RANK_W-1:0]                rank;
    logic [NUM_DIMS-1:0][SIZE_W-1:0]  size;
    logic [NUM_DIMS-1:0][COORD_W-1:0] cin;
    logic                             err;
    logic [FLAT_W:0]                  acc;
    logic [FLAT_W-1:0]                q;
    logic [COORD_W-1:0]               rem;
    logic [NUM_DIMS-1:0][COORD_W-1:0] cout;
  } stage_t;

  // config registers
  logic [RANK_W-1:0]               rank;
  logic [NUM_DIMS-1:0][SIZE_W-1:0] size_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank     <= RANK_W'(1);
      size_dim <= {NUM_DIMS{SIZE_W'(1)}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANK:  rank        <= cfg_data[RANK_W-1:0];
        REG_SIZE0: size_dim[0] <= cfg_data;
        REG_SIZE1: size_dim[1] <= cfg_data;
        REG_SIZE2: size_dim[2] <= cfg_data;
        REG_SIZE3: size_dim[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // one stage of work; op, dim and grp are fixed per stage
  function automatic stage_t stage_op(input stage_t s, input logic [1:0] op,
                                      input logic [1:0] dim, input logic [1:0] grp);
    stage_t          o;
    logic [41:0]     prod;
    logic [SIZE_W-1:0] t;
    logic            qb;
    o = s;
    case (op)
      OP_MUL: begin
        // Horner step, or element count for the flat-to-coord direction
        if ({1'b0, dim} < s.rank) begin
          prod = s.acc * s.size[dim];
          if (s.func == FUNC_TO_FLAT) begin
            o.acc = prod[FLAT_W:0] + (FLAT_W+1)'(s.cin[dim]);
            if ({1'b0, s.cin[dim]} >= s.size[dim]) o.err = 1'b1;
          end else begin
            o.acc = prod[FLAT_W:0];
          end
        end
      end
      OP_CMP: begin
        if (s.func == FUNC_TO_COORD && {1'b0, s.q} >= s.acc) o.err = 1'b1;
      end
      OP_DIV: begin
        // eight restoring division steps, quotient shifts into q
        if ({1'b0, dim} < s.rank) begin
          if (grp == 2'd0) o.rem = '0;
          for (int b = 0; b < 8; b++) begin
            t = {o.rem, o.q[FLAT_W-1]};
            if (t >= o.size[dim]) begin
              t  = t - o.size[dim];
              qb = 1'b1;
            end else begin
              qb = 1'b0;
            end
            o.rem = t[COORD_W-1:0];
            o.q   = {o.q[FLAT_W-2:0], qb};
          end
          if (grp == 2'd3) o.cout[dim] = o.rem;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // entry word: effective rank and sizes, first Horner term
  stage_t                          entry;
  logic [RANK_W-1:0]               eff_rank;
  logic [NUM_DIMS-1:0][SIZE_W-1:0] eff_size;
  logic                            zero_err;

  always_comb begin
    eff_rank = (rank == '0) ? RANK_W'(1) : ((rank > RLIM) ? RLIM : rank);
    zero_err = 1'b0;
    for (int i = 0; i < NUM_DIMS; i++) begin
      if (size_dim[i] == '0) eff_size[i] = SIZE_W'(1);
      else if ({8'b0, size_dim[i]} > CAP) eff_size[i] = CAP[SIZE_W-1:0];
      else eff_size[i] = size_dim[i];
      if (RANK_W'(i) < eff_rank && size_dim[i] == '0) zero_err = 1'b1;
    end
    entry.func    = item.func;
    entry.rank    = eff_rank;
    entry.size    = eff_size;
    entry.cin     = {item.coord_in3, item.coord_in2, item.coord_in1, item.coord_in0};
    entry.q       = item.flat_in;
    entry.rem     = '0;
    entry.cout    = '0;
    entry.err     = zero_err;
    if (item.func == FUNC_TO_FLAT) begin
      entry.acc = (FLAT_W+1)'(item.coord_in0);
      if ({1'b0, item.coord_in0} >= eff_size[0]) entry.err = 1'b1;
    end else begin
      entry.acc = (FLAT_W+1)'(eff_size[0]);
    end
  end

  // pipeline
  stage_t        pipe      [NS];
  stage_t        pipe_next [NS];
  logic [NS-1:0] valid;
  logic [NS-1:0] en;

  assign pipe_next[0] = entry;

  for (genvar j = 1; j < NS; j++) begin : g_stage
    localparam logic [1:0] OP  = (j <= 3) ? OP_MUL : ((j == 4) ? OP_CMP : OP_DIV);
    localparam logic [1:0] DIM = (j <= 3) ? 2'(j) : ((j == 4) ? 2'd0 : 2'(3 - (j - 5) / 4));
    localparam logic [1:0] GRP = (j <= 4) ? 2'd0 : 2'((j - 5) % 4);
    assign pipe_next[j] = stage_op(pipe[j-1], OP, DIM, GRP);
    assign en[j-1]      = !valid[j-1] || en[j];
  end
  assign en[NS-1] = !valid[NS-1] || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= item_valid;
      for (int j = 1; j < NS; j++) begin
        if (en[j]) valid[j] <= valid[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NS; j++) begin
      if (en[j]) pipe[j] <= pipe_next[j];
    end
  end

  // result packing
  assign item_stall   = !en[0];
  assign result_valid = valid[NS-1];

  always_comb begin
    result.range_error = pipe[NS-1].err;
    if (pipe[NS-1].func == FUNC_TO_FLAT) begin
      result.flat_out   = pipe[NS-1].acc[FLAT_W-1:0];
      result.coord_out0 = '0;
      result.coord_out1 = '0;
      result.coord_out2 = '0;
      result.coord_out3 = '0;
    end else begin
      result.flat_out   = '0;
      result.coord_out0 = pipe[NS-1].q[COORD_W-1:0];
      result.coord_out1 = pipe[NS-1].cout[1];
      result.coord_out2 = pipe[NS-1].cout[2];
      result.coord_out3 = pipe[NS-1].cout[3];
    end
  end

  // checks
  a_mode_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.flat_out != '0 |->
      result.coord_out1 == '0 && result.coord_out2 == '0 && result.coord_out3 == '0)
    else $error("flat and coordinate results both set");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("stall raised with empty output stage");

  a_rank_legal: assert property (@(posedge clk) disable iff (rst)
    valid[0] |-> pipe[0].rank != '0 && pipe[0].rank <= RLIM)
    else $error("effective rank out of range");

endmodule
